// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the ordered letter list.
// Depends on nothing; each macro expands to one clocked concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define OLL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ordered letter list: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define OLL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered letter list: next-cycle check failed");

`endif

// ===== design/olist_pkg.sv =====
// Package for the ordered letter list: request and result structs, command and status codes.
// No dependencies; used by the top level and its checker through scoped names.
`default_nettype none

package olist_pkg;

  // Command codes
  localparam logic [3:0] CMD_PUSH_FRONT = 4'd0;
  localparam logic [3:0] CMD_APPEND     = 4'd1;
  localparam logic [3:0] CMD_INS_BEFORE = 4'd2;
  localparam logic [3:0] CMD_INS_AFTER  = 4'd3;
  localparam logic [3:0] CMD_REMOVE     = 4'd4;
  localparam logic [3:0] CMD_HEAD       = 4'd5;
  localparam logic [3:0] CMD_TAIL       = 4'd6;
  localparam logic [3:0] CMD_LENGTH     = 4'd7;
  localparam logic [3:0] CMD_PRINT      = 4'd8;

  // Status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_LETTER = 3'd1;
  localparam logic [2:0] ST_EMPTY      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;

  // Accepted letter range
  localparam logic [7:0] LETTER_A = 8'h41;
  localparam logic [7:0] LETTER_Z = 8'h5A;

  typedef struct packed {
    logic [3:0] command;
    logic [7:0] letter;
    logic [7:0] anchor;
  } in_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] value;
    logic [4:0] entries;
    logic       last;
  } out_res_t;

endpackage

`default_nettype wire

// ===== design/ordered_letter_list.sv =====
// Ordered letter list: a linked list of letters held in a slot memory and a link memory.
// Depends on olist_pkg for the request/result structs and the command and status codes.
//
// A request is taken when start is high and busy is low; busy is high while a request
// is in progress. Results appear on out_res for one cycle each, marked by out_valid, and
// cannot be held off. After reset the link memory is initialised into a free chain, one
// slot a cycle, and busy stays high until the chain is built. An insert before the head
// is a push to the front and an insert after the tail is an append; an insert whose
// anchor is missing appends the letter, and a remove of a missing letter reports not
// found. Print gives one result per entry on consecutive cycles, the last flagged. The
// walk is paced by the read address shared by the two memories, which also serves every
// other read.
`default_nettype none

module ordered_letter_list #(
  parameter int CAPACITY = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  olist_pkg::in_req_t   in_req,
  output logic                 out_valid,
  output olist_pkg::out_res_t  out_res
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Sequencer states
  localparam logic [2:0] S_INIT    = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_HEAD    = 3'd2;
  localparam logic [2:0] S_WALK    = 3'd3;
  localparam logic [2:0] S_COMMIT  = 3'd4;
  localparam logic [2:0] S_COMMIT2 = 3'd5;
  localparam logic [2:0] S_PRINT   = 3'd6;

  // Update kinds applied in the commit states
  localparam logic [2:0] M_FRONT  = 3'd0;
  localparam logic [2:0] M_BACK   = 3'd1;
  localparam logic [2:0] M_BEFORE = 3'd2;
  localparam logic [2:0] M_AFTER  = 3'd3;
  localparam logic [2:0] M_REMOVE = 3'd4;

  // Memories and their registered read data
  logic [7:0]    letter_mem [CAPACITY];
  logic [IW-1:0] link_mem   [CAPACITY];
  logic [7:0]    letter_rd_r;
  logic [IW-1:0] link_rd_r;

  // Control and list registers
  logic [2:0]    state_r, state_nxt;
  logic [2:0]    mode_r, mode_nxt;
  logic [3:0]    cmd_r, cmd_nxt;
  logic [7:0]    letter_r, letter_nxt;
  logic [7:0]    key_r, key_nxt;
  logic [IW-1:0] first_r, first_nxt;
  logic [IW-1:0] last_r, last_nxt;
  logic [IW-1:0] free_r, free_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] before_r, before_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic [IW-1:0] prev_r, prev_nxt;
  logic [IW-1:0] pos_link_r, pos_link_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic [IW-1:0] init_r, init_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] step_r, step_nxt;
  logic                 out_valid_r, out_valid_nxt;
  olist_pkg::out_res_t  out_r, out_nxt;

  // Memory port controls
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          let_we;
  logic [IW-1:0] let_addr;
  logic [7:0]    let_wdata;
  logic          lnk_we;
  logic [IW-1:0] lnk_addr;
  logic [IW-1:0] lnk_wdata;

  // Decode helpers
  logic          is_letter;
  logic          hit;
  logic          last_step;
  logic [31:0]   cnt_wide;

  assign is_letter = (in_req.letter >= olist_pkg::LETTER_A) &&
                     (in_req.letter <= olist_pkg::LETTER_Z);
  assign hit       = (letter_rd_r == key_r);
  assign last_step = (step_r == (count_r - CW'(1)));

  // Slot memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (let_we) letter_mem[let_addr] <= let_wdata;
    if (rd_en) letter_rd_r <= letter_mem[rd_addr];
  end

  // Link memory: one write, one registered read at the same address as the slot memory
  always_ff @(posedge clk) begin
    if (lnk_we) link_mem[lnk_addr] <= lnk_wdata;
    if (rd_en) link_rd_r <= link_mem[rd_addr];
  end

  // Sequencer next-state and memory access decisions
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    cmd_nxt       = cmd_r;
    letter_nxt    = letter_r;
    key_nxt       = key_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    free_nxt      = free_r;
    cur_nxt       = cur_r;
    before_nxt    = before_r;
    pos_nxt       = pos_r;
    prev_nxt      = prev_r;
    pos_link_nxt  = pos_link_r;
    slot_nxt      = slot_r;
    init_nxt      = init_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_addr       = first_r;
    let_we        = 1'b0;
    let_addr      = free_r;
    let_wdata     = letter_r;
    lnk_we        = 1'b0;
    lnk_addr      = free_r;
    lnk_wdata     = first_r;

    case (state_r)
      // Build the free chain: slot i links to slot i+1, wrapping at the end
      S_INIT: begin
        lnk_we   = 1'b1;
        lnk_addr = init_r;
        if (init_r == IW'(CAPACITY - 1)) begin
          lnk_wdata = '0;
          state_nxt = S_IDLE;
        end else begin
          lnk_wdata = init_r + IW'(1);
          init_nxt  = init_r + IW'(1);
        end
      end

      // Take a request and check it
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = in_req.command;
          letter_nxt = in_req.letter;
          key_nxt    = (in_req.command == olist_pkg::CMD_REMOVE) ? in_req.letter
                                                                 : in_req.anchor;
          out_nxt.value = '0;
          out_nxt.last  = 1'b1;
          out_nxt.status = olist_pkg::ST_OK;
          if ((in_req.command <= olist_pkg::CMD_REMOVE) && !is_letter) begin
            out_valid_nxt  = 1'b1;
            out_nxt.status = olist_pkg::ST_BAD_LETTER;
          end else if ((in_req.command <= olist_pkg::CMD_INS_AFTER) &&
                       (count_r == CW'(CAPACITY))) begin
            out_valid_nxt  = 1'b1;
            out_nxt.status = olist_pkg::ST_FULL;
          end else if ((in_req.command >= olist_pkg::CMD_INS_BEFORE) &&
                       (in_req.command <= olist_pkg::CMD_TAIL) && (count_r == '0)) begin
            out_valid_nxt  = 1'b1;
            out_nxt.status = olist_pkg::ST_EMPTY;
          end else begin
            case (in_req.command)
              olist_pkg::CMD_PUSH_FRONT, olist_pkg::CMD_APPEND: begin
                mode_nxt  = (in_req.command == olist_pkg::CMD_APPEND) ? M_BACK : M_FRONT;
                rd_en     = 1'b1;
                rd_addr   = free_r;
                state_nxt = S_COMMIT;
              end
              olist_pkg::CMD_INS_BEFORE, olist_pkg::CMD_INS_AFTER,
              olist_pkg::CMD_REMOVE: begin
                rd_en      = 1'b1;
                rd_addr    = first_r;
                cur_nxt    = first_r;
                before_nxt = first_r;
                step_nxt   = '0;
                state_nxt  = S_WALK;
              end
              olist_pkg::CMD_HEAD: begin
                rd_en     = 1'b1;
                rd_addr   = first_r;
                state_nxt = S_HEAD;
              end
              olist_pkg::CMD_TAIL: begin
                rd_en     = 1'b1;
                rd_addr   = last_r;
                state_nxt = S_HEAD;
              end
              olist_pkg::CMD_PRINT: begin
                if (count_r == '0) begin
                  out_valid_nxt  = 1'b1;
                  out_nxt.status = olist_pkg::ST_EMPTY;
                end else begin
                  rd_en     = 1'b1;
                  rd_addr   = first_r;
                  step_nxt  = '0;
                  state_nxt = S_PRINT;
                end
              end
              default: begin
                // length and unused codes
                out_valid_nxt = 1'b1;
              end
            endcase
          end
        end
      end

      // Head or tail letter has been read
      S_HEAD: begin
        out_valid_nxt  = 1'b1;
        out_nxt.status = olist_pkg::ST_OK;
        out_nxt.value  = letter_rd_r;
        out_nxt.last   = 1'b1;
        state_nxt      = S_IDLE;
      end

      // Search the chain one entry a cycle
      S_WALK: begin
        if (hit) begin
          pos_nxt      = cur_r;
          prev_nxt     = before_r;
          pos_link_nxt = link_rd_r;
          state_nxt    = S_COMMIT;
          case (cmd_r)
            olist_pkg::CMD_INS_BEFORE: begin
              mode_nxt = (cur_r == first_r) ? M_FRONT : M_BEFORE;
              rd_en    = 1'b1;
              rd_addr  = free_r;
            end
            olist_pkg::CMD_INS_AFTER: begin
              mode_nxt = (cur_r == last_r) ? M_BACK : M_AFTER;
              rd_en    = 1'b1;
              rd_addr  = free_r;
            end
            default: mode_nxt = M_REMOVE;
          endcase
        end else if (last_step) begin
          if (cmd_r == olist_pkg::CMD_REMOVE) begin
            out_valid_nxt  = 1'b1;
            out_nxt.status = olist_pkg::ST_NOT_FOUND;
            out_nxt.value  = '0;
            out_nxt.last   = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            // anchor missing: the letter goes to the end
            mode_nxt  = M_BACK;
            rd_en     = 1'b1;
            rd_addr   = free_r;
            state_nxt = S_COMMIT;
          end
        end else begin
          before_nxt = cur_r;
          cur_nxt    = link_rd_r;
          step_nxt   = step_r + CW'(1);
          rd_en      = 1'b1;
          rd_addr    = link_rd_r;
        end
      end

      // First write cycle; link_rd_r holds the link of the free head for inserts
      S_COMMIT: begin
        slot_nxt = free_r;
        case (mode_r)
          M_FRONT: begin
            free_nxt  = link_rd_r;
            let_we    = 1'b1;
            count_nxt = count_r + CW'(1);
            if (count_r == '0) begin
              last_nxt = free_r;
            end else begin
              lnk_we    = 1'b1;
              lnk_addr  = free_r;
              lnk_wdata = first_r;
            end
            first_nxt = free_r;
          end
          M_BACK: begin
            free_nxt  = link_rd_r;
            let_we    = 1'b1;
            count_nxt = count_r + CW'(1);
            if (count_r == '0) begin
              first_nxt = free_r;
            end else begin
              lnk_we    = 1'b1;
              lnk_addr  = last_r;
              lnk_wdata = free_r;
            end
            last_nxt = free_r;
          end
          M_BEFORE: begin
            free_nxt  = link_rd_r;
            let_we    = 1'b1;
            count_nxt = count_r + CW'(1);
            lnk_we    = 1'b1;
            lnk_addr  = free_r;
            lnk_wdata = pos_r;
          end
          M_AFTER: begin
            free_nxt  = link_rd_r;
            let_we    = 1'b1;
            count_nxt = count_r + CW'(1);
            lnk_we    = 1'b1;
            lnk_addr  = free_r;
            lnk_wdata = pos_link_r;
          end
          default: begin
            // remove: unlink, then return the slot to the free chain
            if (pos_r == first_r) begin
              first_nxt = pos_link_r;
            end else begin
              lnk_we    = 1'b1;
              lnk_addr  = prev_r;
              lnk_wdata = pos_link_r;
            end
            if (pos_r == last_r) last_nxt = prev_r;
            count_nxt = count_r - CW'(1);
            free_nxt  = pos_r;
          end
        endcase
        if ((mode_r == M_FRONT) || (mode_r == M_BACK)) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = olist_pkg::ST_OK;
          out_nxt.value  = '0;
          out_nxt.last   = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_COMMIT2;
        end
      end

      // Second link write for middle inserts and remove
      S_COMMIT2: begin
        lnk_we    = 1'b1;
        lnk_wdata = slot_r;
        lnk_addr  = (mode_r == M_BEFORE) ? prev_r : pos_r;
        out_valid_nxt  = 1'b1;
        out_nxt.status = olist_pkg::ST_OK;
        out_nxt.value  = '0;
        out_nxt.last   = 1'b1;
        state_nxt      = S_IDLE;
      end

      // Stream the list, one entry a cycle
      S_PRINT: begin
        out_valid_nxt  = 1'b1;
        out_nxt.status = olist_pkg::ST_OK;
        out_nxt.value  = letter_rd_r;
        out_nxt.last   = last_step;
        if (last_step) begin
          state_nxt = S_IDLE;
        end else begin
          step_nxt = step_r + CW'(1);
          rd_en    = 1'b1;
          rd_addr  = link_rd_r;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Entry count after the request, cut to the result field
    cnt_wide        = 32'(count_nxt);
    out_nxt.entries = cnt_wide[4:0];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_r      <= '0;
      first_r     <= '0;
      last_r      <= '0;
      free_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      free_r      <= free_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    cmd_r      <= cmd_nxt;
    letter_r   <= letter_nxt;
    key_r      <= key_nxt;
    cur_r      <= cur_nxt;
    before_r   <= before_nxt;
    pos_r      <= pos_nxt;
    prev_r     <= prev_nxt;
    pos_link_r <= pos_link_nxt;
    slot_r     <= slot_nxt;
    step_r     <= step_nxt;
    out_r      <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

`default_nettype wire

// ===== design/olist_checker.sv =====
// Port-level checks for the ordered letter list, bound to the top level.
// Depends on olist_pkg for codes and on assert_macros.svh for the assertion forms.
`default_nettype none

`include "assert_macros.svh"

module olist_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  start,
  input wire                  busy,
  input olist_pkg::in_req_t   in_req,
  input wire                  out_valid,
  input olist_pkg::out_res_t  out_res
);

  logic acc;
  logic bad_letter;

  assign acc        = start && !busy;
  assign bad_letter = (in_req.letter < olist_pkg::LETTER_A) ||
                      (in_req.letter > olist_pkg::LETTER_Z);

  // A rejected letter is reported in the very next cycle
  `OLL_ASSERT_NEXT(a_bad_letter, clk, rst_n, acc && (in_req.command <= olist_pkg::CMD_REMOVE) && bad_letter, out_valid && out_res.last && (out_res.status == olist_pkg::ST_BAD_LETTER))

  // A length request answers in the next cycle with a single good result
  `OLL_ASSERT_NEXT(a_length, clk, rst_n, acc && (in_req.command == olist_pkg::CMD_LENGTH), out_valid && out_res.last && (out_res.status == olist_pkg::ST_OK))

  // Any error ends its request
  `OLL_ASSERT_NOW(a_err_last, clk, rst_n, out_valid && (out_res.status != olist_pkg::ST_OK), out_res.last)

  // A print stream has no gaps until its final entry
  `OLL_ASSERT_NEXT(a_print_stream, clk, rst_n, out_valid && !out_res.last, out_valid)

  // No new request is taken while a multi-result stream is still running
  `OLL_ASSERT_NOW(a_busy_stream, clk, rst_n, out_valid && !out_res.last, busy)

endmodule

bind ordered_letter_list olist_checker u_olist_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_res   (out_res)
);

`default_nettype wire
